[rtl/assert_macros.svh]
// assertion macros used by the converter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define ASSERT_P(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// implication checked in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequence is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_P(lbl, prop)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/u8u16_pkg.sv]
// shared types and constants of the utf-8 to utf-16 stream converter
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned PointW = 21;

  localparam logic [UnitW-1:0]  HiSurBase  = 16'hD800;
  localparam logic [UnitW-1:0]  LoSurBase  = 16'hDC00;
  localparam logic [25:0]       SupplBase  = 26'h0010000;
  localparam logic [ByteW-1:0]  ContMask   = 8'b0011_1111;
  localparam logic [ByteW-1:0]  Lead2Mask  = 8'b1110_0000;
  localparam logic [ByteW-1:0]  Lead2Code  = 8'b1100_0000;
  localparam logic [ByteW-1:0]  Lead3Mask  = 8'b1111_0000;
  localparam logic [ByteW-1:0]  Lead3Code  = 8'b1110_0000;
  localparam logic [ByteW-1:0]  Lead4Mask  = 8'b1111_1000;
  localparam logic [ByteW-1:0]  Lead4Code  = 8'b1111_0000;

  // one result transaction
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             unit_valid;
    logic             msg_error;
    logic             msg_end;
  } unit_res_t;

endpackage

[rtl/u8u16_if.sv]
// stream interfaces for utf-8 bytes in and utf-16 units out
interface u8u16_byte_if;
  logic                           valid;
  logic                           ready;
  logic [u8u16_pkg::ByteW-1:0]    in_byte;
  logic                           in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8u16_unit_if;
  logic                           valid;
  logic                           ready;
  logic [u8u16_pkg::UnitW-1:0]    code_unit;
  logic                           unit_valid;
  logic                           msg_error;
  logic                           msg_end;

  modport source (output valid, output code_unit, output unit_valid,
                  output msg_error, output msg_end, input ready);
  modport sink (input valid, input code_unit, input unit_valid,
                input msg_error, input msg_end, output ready);
endinterface

[rtl/utf8_to_utf16_stream.sv]
// utf-8 to utf-16 stream converter top level
// a result is written to the output register at the edge that takes its byte
// throughput: one byte per cycle while the output accepts; a 4-byte sequence's low surrogate sits in a
//   second register and holds off input until it moves into the output register
// reset: asynchronous, active low; clears the decode state and the valid flags of
//   both result registers
`include "assert_macros.svh"

module utf8_to_utf16_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8u16_byte_if.sink  in_i,
  u8u16_unit_if.source out_o
);

  // decode state
  logic [u8u16_pkg::PointW-1:0] point_q, point_d;
  logic [1:0]                   pending_q, pending_d;
  logic                         four_q, four_d;
  logic                         err_q, err_d;

  // result registers
  u8u16_pkg::unit_res_t out_q, out_d, pend_q, pend_d;
  logic                 out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;

  logic in_ready, in_fire, out_fire;
  logic [u8u16_pkg::ByteW-1:0] b;
  logic [u8u16_pkg::PointW-1:0] shifted;
  logic [25:0] sur_v;
  logic [1:0]  n_units;
  logic [1:0]  n_res;
  logic [u8u16_pkg::UnitW-1:0] unit0, unit1;
  u8u16_pkg::unit_res_t res0, res1;

  assign in_ready  = !pend_valid_q && (!out_valid_q || out_o.ready);
  assign in_fire   = in_i.valid && in_ready;
  assign out_fire  = out_valid_q && out_o.ready;
  assign in_i.ready = in_ready;

  assign b       = in_i.in_byte;
  assign shifted = {point_q[u8u16_pkg::PointW-7:0], b[5:0] & u8u16_pkg::ContMask[5:0]};
  assign sur_v   = {5'd0, shifted} - u8u16_pkg::SupplBase;

  // byte decode
  always_comb begin
    point_d   = point_q;
    pending_d = pending_q;
    four_d    = four_q;
    err_d     = err_q;
    n_units   = 2'd0;
    unit0     = '0;
    unit1     = '0;
    if (!err_q) begin
      if (pending_q != 2'd0) begin
        point_d   = shifted;
        pending_d = pending_q - 2'd1;
        if (pending_q == 2'd1) begin
          if (four_q) begin
            unit0   = u8u16_pkg::HiSurBase + sur_v[25:10];
            unit1   = u8u16_pkg::LoSurBase + {6'd0, sur_v[9:0]};
            n_units = 2'd2;
          end else begin
            unit0   = shifted[u8u16_pkg::UnitW-1:0];
            n_units = 2'd1;
          end
          point_d = '0;
          four_d  = 1'b0;
        end
      end else if (!b[7]) begin
        unit0   = {8'd0, b};
        n_units = 2'd1;
      end else if ((b & u8u16_pkg::Lead2Mask) == u8u16_pkg::Lead2Code) begin
        point_d   = {16'd0, b[4:0]};
        pending_d = 2'd1;
        four_d    = 1'b0;
      end else if ((b & u8u16_pkg::Lead3Mask) == u8u16_pkg::Lead3Code) begin
        point_d   = {17'd0, b[3:0]};
        pending_d = 2'd2;
        four_d    = 1'b0;
      end else if ((b & u8u16_pkg::Lead4Mask) == u8u16_pkg::Lead4Code) begin
        point_d   = {18'd0, b[2:0]};
        pending_d = 2'd3;
        four_d    = 1'b1;
      end else begin
        err_d = 1'b1;
      end
    end
  end

  // build the result transactions of this byte
  always_comb begin
    res0 = '{code_unit: unit0, unit_valid: 1'b1, msg_error: 1'b0, msg_end: 1'b0};
    res1 = '{code_unit: unit1, unit_valid: 1'b1, msg_error: 1'b0, msg_end: 1'b0};
    n_res = n_units;
    if (in_i.in_last) begin
      case (n_units)
        2'd0: begin
          res0  = '{code_unit: '0, unit_valid: 1'b0, msg_error: err_d, msg_end: 1'b1};
          n_res = 2'd1;
        end
        2'd1: begin
          res0.msg_error = err_d;
          res0.msg_end   = 1'b1;
        end
        2'd2: begin
          res1.msg_error = err_d;
          res1.msg_end   = 1'b1;
        end
        default: begin
          n_res = n_units;
        end
      endcase
    end
  end

  // result register control
  always_comb begin
    out_d        = out_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    if (out_fire) begin
      if (pend_valid_q) begin
        out_d        = pend_q;
        pend_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (in_fire && (n_res != 2'd0)) begin
      out_d       = res0;
      out_valid_d = 1'b1;
      if (n_res == 2'd2) begin
        pend_d       = res1;
        pend_valid_d = 1'b1;
      end
    end
  end

  // control and decode state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q      <= '0;
      pending_q    <= '0;
      four_q       <= 1'b0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (in_fire) begin
        if (in_i.in_last) begin
          point_q   <= '0;
          pending_q <= '0;
          four_q    <= 1'b0;
          err_q     <= 1'b0;
        end else begin
          point_q   <= point_d;
          pending_q <= pending_d;
          four_q    <= four_d;
          err_q     <= err_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.code_unit  = out_q.code_unit;
  assign out_o.unit_valid = out_q.unit_valid;
  assign out_o.msg_error  = out_q.msg_error;
  assign out_o.msg_end    = out_q.msg_end;

  // checks
  `ASSERT_IMPL(a_pend_behind_out, pend_valid_q, out_valid_q)
  `ASSERT_IMPL(a_pend_blocks_input, pend_valid_q, !in_ready)
  `ASSERT_IMPL(a_pend_is_low_sur, pend_valid_q, pend_q.unit_valid && (pend_q.code_unit[15:10] == 6'b110111))
  `ASSERT_NEXT(a_last_clears, in_fire && in_i.in_last, (pending_q == 2'd0) && !err_q && !four_q)

endmodule

[tb/sv/utf8_to_utf16_stream_tb.sv]
// testbench for the utf-8 to utf-16 stream converter: directed and random byte messages
`timescale 1ns / 100ps

module utf8_to_utf16_stream_tb;

  localparam int unsigned ByteTarget = 1150;
  localparam int unsigned BurstBytes = 150;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned IdlePct    = 13;
  localparam int unsigned MaxPrinted = 20;

  logic clk_i;
  logic rst_ni;

  u8u16_byte_if in_if ();
  u8u16_unit_if out_if ();

  utf8_to_utf16_stream dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // decoder mirror and the units it still owes
  logic [u8u16_pkg::PointW-1:0] point_acc;
  logic [1:0]                   conts_left;
  logic                         four_byte_seq;
  logic                         bad_lead_seen;
  u8u16_pkg::unit_res_t         units_due[$];

  int unsigned decoded_bytes = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_cycles  = 0;
  bit          no_idle       = 1'b0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // work out the units one accepted byte causes
  function automatic void predict_units(input logic [u8u16_pkg::ByteW-1:0] b,
                                        input logic last);
    logic [u8u16_pkg::UnitW-1:0] units[2];
    int                          n;
    logic [31:0]                 offs;
    u8u16_pkg::unit_res_t        r;
    n = 0;
    decoded_bytes++;
    if (!bad_lead_seen) begin
      if (conts_left != 2'd0) begin
        point_acc  = {point_acc[u8u16_pkg::PointW-7:0], 6'(b & u8u16_pkg::ContMask)};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          if (four_byte_seq) begin
            // surrogate math wraps at 32 bits, then keeps 16
            offs = 32'(point_acc) - 32'(u8u16_pkg::SupplBase);
            units[n] = 16'(32'(u8u16_pkg::HiSurBase) + (offs >> 10));
            n++;
            units[n] = u8u16_pkg::LoSurBase + 16'(offs[9:0]);
            n++;
          end else begin
            units[n] = point_acc[u8u16_pkg::UnitW-1:0];
            n++;
          end
          point_acc     = '0;
          four_byte_seq = 1'b0;
        end
      end else if (!b[7]) begin
        units[n] = {8'h00, b};
        n++;
      end else if ((b & u8u16_pkg::Lead2Mask) == u8u16_pkg::Lead2Code) begin
        point_acc     = {13'd0, b & ~u8u16_pkg::Lead2Mask};
        conts_left    = 2'd1;
        four_byte_seq = 1'b0;
      end else if ((b & u8u16_pkg::Lead3Mask) == u8u16_pkg::Lead3Code) begin
        point_acc     = {13'd0, b & ~u8u16_pkg::Lead3Mask};
        conts_left    = 2'd2;
        four_byte_seq = 1'b0;
      end else if ((b & u8u16_pkg::Lead4Mask) == u8u16_pkg::Lead4Code) begin
        point_acc     = {13'd0, b & ~u8u16_pkg::Lead4Mask};
        conts_left    = 2'd3;
        four_byte_seq = 1'b1;
      end else begin
        bad_lead_seen = 1'b1;
      end
    end

    for (int k = 0; k < n; k++) begin
      r.code_unit  = units[k];
      r.unit_valid = 1'b1;
      r.msg_end    = last && (k == n - 1);
      r.msg_error  = r.msg_end ? bad_lead_seen : 1'b0;
      units_due.push_back(r);
    end

    // end of message: bare marker if nothing else carried the end flag
    if (last) begin
      if (n == 0) begin
        r.code_unit  = '0;
        r.unit_valid = 1'b0;
        r.msg_error  = bad_lead_seen;
        r.msg_end    = 1'b1;
        units_due.push_back(r);
      end
      point_acc     = '0;
      conts_left    = 2'd0;
      four_byte_seq = 1'b0;
      bad_lead_seen = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [u8u16_pkg::UnitW-1:0] got,
                                 input logic [u8u16_pkg::UnitW-1:0] want);
    if (mismatches < MaxPrinted)
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // drive one byte and wait until it is accepted
  task automatic send_byte(input logic [u8u16_pkg::ByteW-1:0] b, input logic last);
    while (!no_idle && ($urandom_range(99) < IdlePct)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_units(b, last);
  endtask

  task automatic send_message(input logic [u8u16_pkg::ByteW-1:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // hold the sender until every owed unit has come out
  task automatic wait_units_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (units_due.size() != 0);
  endtask

  function automatic logic [u8u16_pkg::ByteW-1:0] cont_byte();
    // continuation bytes are not checked, so now and then send anything
    if ($urandom_range(9) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // mostly well-formed sequences, some stray, invalid or cut-off bytes
  task automatic send_random_message();
    logic [u8u16_pkg::ByteW-1:0] msg[$];
    int unsigned                 n_seq;
    int unsigned                 kind;
    n_seq = $urandom_range(1, 10);
    repeat (n_seq) begin
      kind = $urandom_range(99);
      if (kind < 32) begin
        msg.push_back({1'b0, 7'($urandom)});
      end else if (kind < 54) begin
        msg.push_back({3'b110, 5'($urandom)});
        msg.push_back(cont_byte());
      end else if (kind < 72) begin
        msg.push_back({4'b1110, 4'($urandom)});
        repeat (2) msg.push_back(cont_byte());
      end else if (kind < 90) begin
        msg.push_back({5'b11110, 3'($urandom)});
        repeat (3) msg.push_back(cont_byte());
      end else if (kind < 92) begin
        msg.push_back({2'b10, 6'($urandom)});
      end else if (kind < 94) begin
        msg.push_back({5'b11111, 3'($urandom)});
      end else if (kind < 98) begin
        msg.push_back($urandom_range(1) ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)});
        repeat ($urandom_range(0, 1)) msg.push_back(cont_byte());
      end else begin
        msg.push_back(8'($urandom));
      end
    end
    send_message(msg);
  endtask

  // ascii extremes and a lead byte cut off by the end
  task automatic test_single_bytes();
    send_message('{8'h00});
    send_message('{8'h7F, 8'hC2});
  endtask

  // two-, three- and four-byte sequences, surrogate wrap at both ends, end flag on a low surrogate
  task automatic test_sequences();
    send_message('{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h80, 8'h80, 8'h80,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF});
  endtask

  // stray continuation and invalid leads set the sticky error
  task automatic test_bad_leads();
    send_message('{8'h80, 8'h41});
    send_message('{8'hF8, 8'hFF});
  endtask

  // a lead byte inside a pending sequence acts as continuation, then the end cuts it
  task automatic test_truncation();
    send_message('{8'hE2, 8'hC3});
  endtask

  // both sides with no idling at all
  task automatic test_back_to_back();
    int unsigned stop_at;
    stop_at = decoded_bytes + BurstBytes;
    no_idle = 1'b1;
    while (decoded_bytes < stop_at) send_random_message();
    no_idle = 1'b0;
  endtask

  task automatic test_random_messages();
    while (decoded_bytes < ByteTarget) begin
      send_random_message();
      if ($urandom_range(29) == 0) wait_units_drained();
    end
  endtask

  // output ready with random stalls
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // compare each output transaction with the oldest owed unit
  always @(posedge clk_i) begin : check_units
    u8u16_pkg::unit_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (units_due.size() == 0) begin
        report_mismatch("unexpected unit", out_if.code_unit, '0);
      end else begin
        want = units_due.pop_front();
        if (out_if.code_unit !== want.code_unit)
          report_mismatch("code_unit", out_if.code_unit, want.code_unit);
        if (out_if.unit_valid !== want.unit_valid)
          report_mismatch("unit_valid", 16'(out_if.unit_valid), 16'(want.unit_valid));
        if (out_if.msg_error !== want.msg_error)
          report_mismatch("msg_error", 16'(out_if.msg_error), 16'(want.msg_error));
        if (out_if.msg_end !== want.msg_end)
          report_mismatch("msg_end", 16'(out_if.msg_end), 16'(want.msg_end));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("utf8_to_utf16_stream_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    point_acc     = '0;
    conts_left    = 2'd0;
    four_byte_seq = 1'b0;
    bad_lead_seen = 1'b0;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    in_if.in_last <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_single_bytes();
    test_sequences();
    test_bad_leads();
    test_truncation();
    wait_units_drained();
    test_back_to_back();
    wait_units_drained();
    test_random_messages();
    wait_units_drained();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && units_due.size() == 0) begin
      $display("utf8_to_utf16_stream_tb OK");
    end else begin
      $display("utf8_to_utf16_stream_tb NOT OK");
    end
    $finish;
  end

endmodule
